// ----- design/diagonal_kalman_position_filter_top_macros.svh -----
// Assertion macros for the position filter.
// Needs clk_i and rst_ni in the scope of use.
`ifndef DIAGONAL_KALMAN_POSITION_FILTER_TOP_MACROS_SVH
`define DIAGONAL_KALMAN_POSITION_FILTER_TOP_MACROS_SVH

// Checked on every clock edge outside reset.
`define DKPF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define DKPF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- design/dkpf_pkg.sv -----
// Shared types and codes of the position filter.
// No dependencies.
package dkpf_pkg;

  typedef enum logic [3:0] {
    KIND_PREDICT   = 4'd0,
    KIND_IMU       = 4'd1,
    KIND_ODOMETRY  = 4'd2,
    KIND_SATELLITE = 4'd3,
    KIND_POSE      = 4'd4,
    KIND_CUSTOM    = 4'd5,
    KIND_LOAD_POS  = 4'd6,
    KIND_LOAD_VEL  = 4'd7,
    KIND_RESET_VAR = 4'd8
  } kind_e;

  typedef enum logic [2:0] {
    CFG_NOISE_ODOMETRY   = 3'd0,
    CFG_NOISE_SATELLITE  = 3'd1,
    CFG_NOISE_POSE       = 3'd2,
    CFG_NOISE_CUSTOM_DEF = 3'd3,
    CFG_PROCESS_RATE     = 3'd4,
    CFG_ACCEL_STEP       = 3'd5,
    CFG_INITIAL_VARIANCE = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [3:0]         kind;
    logic [30:0]        step_time;
    logic signed [31:0] value_x;
    logic signed [31:0] value_y;
    logic signed [31:0] value_z;
    logic [30:0]        noise_x;
    logic [30:0]        noise_y;
    logic [30:0]        noise_z;
    logic [2:0]         noise_present;
    logic [1:0]         axis_count;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] position_x;
    logic signed [31:0] position_y;
    logic signed [31:0] position_z;
    logic signed [31:0] velocity_x;
    logic signed [31:0] velocity_y;
    logic signed [31:0] velocity_z;
    logic [30:0]        variance_x;
    logic [30:0]        variance_y;
    logic [30:0]        variance_z;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [30:0] value;
  } cfg_req_t;

endpackage

// ----- design/dkpf_stream_if.sv -----
// Valid/ready channel carrying one payload of type T.
// Used with the payload types of dkpf_pkg.
interface dkpf_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/diagonal_kalman_position_filter_top.sv -----
// Three-axis diagonal Kalman position filter, Q format fixed point.
// Depends on dkpf_pkg, dkpf_stream_if and the assertion macro header.
//
// Channels: in_i takes one event request (predict, IMU, measurement, loads),
// out_o returns one request with position, velocity and variance after it,
// cfg_i writes the seven noise/time registers (always ready, write only
// while the filter is idle).
// Datapath: one shared 34x34 multiplier and a bit-serial restoring divider
// work the axes one after another under a small sequencer. Per axis:
// predict updates position, then variance; IMU updates velocity; a
// measurement runs the divider for the gain, then updates both; loads write
// one register. The divider loop is the longest part of a Q16.16 GPS update.
// in_i.ready is high only while idle; one event is in work at a time.
// The result waits in an output register; if out_o is stalled the
// sequencer holds in its output step and takes no new event.
// Reset clears position, velocity, variance and output valid, returns to idle and loads the register defaults.
`include "diagonal_kalman_position_filter_top_macros.svh"

module diagonal_kalman_position_filter_top
  import dkpf_pkg::*;
#(
  parameter int AXES          = 3,
  parameter int FRACTION_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  dkpf_stream_if.sink   in_i,
  dkpf_stream_if.source out_o,
  dkpf_stream_if.sink   cfg_i
);

  localparam int KW = FRACTION_BITS + 1;        // gain width, gain <= 1.0
  localparam int CW = $clog2(FRACTION_BITS + 1);
  localparam logic [KW-1:0] ONE_Q = KW'(1) << FRACTION_BITS;
  localparam logic [CW-1:0] DIV_STEPS = CW'(FRACTION_BITS);
  localparam logic [1:0] AXES_N = 2'(AXES);

  typedef enum logic [2:0] {
    ST_IDLE, ST_AXIS, ST_DIV, ST_MUL_A, ST_APPLY_A, ST_MUL_B, ST_APPLY_B, ST_OUT
  } state_e;

  state_e state_q;
  in_item_t item_q;
  logic [1:0] ax_q;
  logic signed [31:0] pos_q [3];
  logic signed [31:0] vel_q [3];
  logic [30:0] var_q [3];
  logic [30:0] reg_q [7];
  logic [KW-1:0] k_q;
  logic [CW-1:0] cnt_q;
  logic [32:0] rem_q;
  logic signed [67:0] prod_q;
  logic out_valid_q;
  out_item_t out_q;

  // per-axis operand selection
  logic signed [31:0] pos_cur, vel_cur, val_cur;
  logic [30:0] var_cur, nz_cur, r_sel;
  logic [31:0] den;
  logic signed [32:0] diff;
  logic is_meas;
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod_d, shifted;
  logic signed [68:0] acc_sum, var_sum;
  logic signed [31:0] acc_sat;
  logic [30:0] var_sat;
  logic [33:0] rem2;
  logic div_ge;
  logic in_fire;
  out_item_t out_d;

  assign in_fire = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data = out_q;

  always_comb begin
    pos_cur = pos_q[ax_q];
    vel_cur = vel_q[ax_q];
    var_cur = var_q[ax_q];
    unique case (ax_q)
      2'd0: begin val_cur = item_q.value_x; nz_cur = item_q.noise_x; end
      2'd1: begin val_cur = item_q.value_y; nz_cur = item_q.noise_y; end
      default: begin val_cur = item_q.value_z; nz_cur = item_q.noise_z; end
    endcase
    is_meas = 1'b0;
    r_sel = reg_q[CFG_NOISE_CUSTOM_DEF];
    unique case (item_q.kind)
      KIND_ODOMETRY: begin is_meas = 1'b1; r_sel = reg_q[CFG_NOISE_ODOMETRY]; end
      KIND_SATELLITE: begin is_meas = 1'b1; r_sel = reg_q[CFG_NOISE_SATELLITE]; end
      KIND_POSE: begin is_meas = 1'b1; r_sel = reg_q[CFG_NOISE_POSE]; end
      KIND_CUSTOM: begin
        is_meas = (ax_q < item_q.axis_count);
        if (item_q.noise_present[ax_q]) r_sel = nz_cur;
      end
      default: ;
    endcase
    den = {1'b0, var_cur} + {1'b0, r_sel};
    diff = 33'(val_cur) - 33'(pos_cur);

    // shared multiplier operands
    mul_a = 34'(vel_cur);
    mul_b = 34'($signed({3'b000, item_q.step_time}));
    if (item_q.kind == KIND_PREDICT) begin
      if (state_q == ST_MUL_B) mul_a = 34'($signed({3'b000, reg_q[CFG_PROCESS_RATE]}));
    end else if (item_q.kind == KIND_IMU) begin
      mul_a = 34'(val_cur);
      mul_b = 34'($signed({3'b000, reg_q[CFG_ACCEL_STEP]}));
    end else if (state_q == ST_MUL_B) begin
      mul_a = 34'($signed({3'b000, var_cur}));
      mul_b = 34'($signed({1'b0, ONE_Q - k_q}));
    end else begin
      mul_a = 34'(diff);
      mul_b = 34'($signed({1'b0, k_q}));
    end
    prod_d = mul_a * mul_b;
    shifted = prod_q >>> FRACTION_BITS;

    acc_sum = 69'((item_q.kind == KIND_IMU) ? vel_cur : pos_cur) + 69'(shifted);
    if (acc_sum > 69'sd2147483647) acc_sat = 32'h7FFF_FFFF;
    else if (acc_sum < -69'sd2147483648) acc_sat = 32'h8000_0000;
    else acc_sat = acc_sum[31:0];
    // predict grows the variance, a measurement replaces it
    var_sum = (is_meas ? 69'sd0 : 69'($signed({1'b0, var_cur}))) + 69'(shifted);
    var_sat = (var_sum > 69'sd2147483647) ? 31'h7FFF_FFFF : var_sum[30:0];

    rem2 = {rem_q, 1'b0};
    div_ge = (rem2 >= {2'b00, den});

    out_d.position_x = pos_q[0];
    out_d.position_y = pos_q[1];
    out_d.position_z = pos_q[2];
    out_d.velocity_x = vel_q[0];
    out_d.velocity_y = vel_q[1];
    out_d.velocity_z = vel_q[2];
    out_d.variance_x = var_q[0];
    out_d.variance_y = var_q[1];
    out_d.variance_z = var_q[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ax_q <= 2'd0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        pos_q[i] <= '0;
        vel_q[i] <= '0;
        var_q[i] <= '0;
      end
      reg_q[CFG_NOISE_ODOMETRY] <= 31'd3277;
      reg_q[CFG_NOISE_SATELLITE] <= 31'd196608;
      reg_q[CFG_NOISE_POSE] <= 31'd1311;
      reg_q[CFG_NOISE_CUSTOM_DEF] <= 31'd6554;
      reg_q[CFG_PROCESS_RATE] <= 31'd66;
      reg_q[CFG_ACCEL_STEP] <= 31'd655;
      reg_q[CFG_INITIAL_VARIANCE] <= 31'd66;
    end else begin
      if (cfg_i.valid && (cfg_i.data.index <= CFG_INITIAL_VARIANCE)) begin
        reg_q[cfg_i.data.index] <= cfg_i.data.value;
      end
      // the output step reloads the register itself
      if (out_valid_q && out_o.ready && (state_q != ST_OUT)) out_valid_q <= 1'b0;

      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            item_q <= in_i.data;
            ax_q <= 2'd0;
            state_q <= ST_AXIS;
          end
        end
        ST_AXIS: begin
          if (ax_q >= AXES_N) begin
            state_q <= ST_OUT;
          end else if (item_q.kind == KIND_PREDICT || item_q.kind == KIND_IMU) begin
            state_q <= ST_MUL_A;
          end else if (is_meas) begin
            if (den == 32'd0) begin
              ax_q <= ax_q + 2'd1;
            end else begin
              // leading quotient bit, then FRACTION_BITS serial steps
              k_q <= KW'({var_cur} >= den[30:0] && !den[31]);
              rem_q <= ({1'b0, var_cur} >= den) ? 33'({1'b0, var_cur} - den)
                                                : {2'b00, var_cur};
              cnt_q <= DIV_STEPS;
              state_q <= ST_DIV;
            end
          end else begin
            unique case (item_q.kind)
              KIND_LOAD_POS: pos_q[ax_q] <= val_cur;
              KIND_LOAD_VEL: vel_q[ax_q] <= val_cur;
              KIND_RESET_VAR: var_q[ax_q] <= reg_q[CFG_INITIAL_VARIANCE];
              default: ;
            endcase
            ax_q <= ax_q + 2'd1;
          end
        end
        ST_DIV: begin
          rem_q <= div_ge ? 33'(rem2 - {2'b00, den}) : rem2[32:0];
          k_q <= {k_q[KW-2:0], div_ge};
          cnt_q <= cnt_q - CW'(1);
          if (cnt_q == CW'(1)) state_q <= ST_MUL_A;
        end
        ST_MUL_A: begin
          prod_q <= prod_d;
          state_q <= ST_APPLY_A;
        end
        ST_APPLY_A: begin
          if (item_q.kind == KIND_IMU) begin
            vel_q[ax_q] <= acc_sat;
            ax_q <= ax_q + 2'd1;
            state_q <= ST_AXIS;
          end else begin
            pos_q[ax_q] <= acc_sat;
            state_q <= ST_MUL_B;
          end
        end
        ST_MUL_B: begin
          prod_q <= prod_d;
          state_q <= ST_APPLY_B;
        end
        ST_APPLY_B: begin
          var_q[ax_q] <= var_sat;
          ax_q <= ax_q + 2'd1;
          state_q <= ST_AXIS;
        end
        ST_OUT: begin
          if (!out_valid_q || out_o.ready) begin
            out_q <= out_d;
            out_valid_q <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `DKPF_ASSERT(busy_after_accept, in_fire |=> !in_i.ready, "accepted while busy")
  `DKPF_ASSERT(axis_in_range, ax_q <= AXES_N, "axis counter past AXES")
  `DKPF_ASSERT(gain_at_most_one, (state_q == ST_MUL_A && is_meas) |-> (k_q <= ONE_Q), "gain above one")
  `DKPF_ASSERT_ALWAYS(no_out_in_reset, !rst_ni |-> !out_o.valid, "valid during reset")

endmodule
